// ===== hw/rtl/tksi_pkg.sv =====
// ----------------------------------------------------------------------------
// tksi_pkg: shared types and constants for the top-K sorted insertion list.
// Holds the transaction classes, the queued item, the result and the
// sequencer states.
// ----------------------------------------------------------------------------
package tksi_pkg;

    localparam int unsigned DATA_W      = 64;
    localparam int unsigned RANK_W      = 9;
    localparam int unsigned COUNT_W     = 10;
    localparam int unsigned LIMIT_W     = 10;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd500;

    typedef enum logic [1:0] {
        CLS_SKIP,
        CLS_OFFER,
        CLS_READ
    } item_class_t;

    typedef struct packed {
        item_class_t              cls;
        logic signed [DATA_W-1:0] score;
        logic [DATA_W-1:0]        seq_index;
        logic signed [DATA_W-1:0] seed;
        logic [RANK_W-1:0]        read_rank;
    } item_t;

    typedef struct packed {
        logic                     inserted;
        logic [RANK_W-1:0]        insert_rank;
        logic                     dropped_last;
        logic [COUNT_W-1:0]       entry_count;
        logic                     entry_valid;
        logic signed [DATA_W-1:0] entry_score;
        logic [DATA_W-1:0]        entry_seq_index;
        logic signed [DATA_W-1:0] entry_seed;
    } result_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SRCH,
        BK_SRCH_CMP,
        BK_SHIFT,
        BK_SHIFT_WR,
        BK_PLACE,
        BK_READ_RD,
        BK_READ_WAIT,
        BK_RESULT
    } back_state_t;

endpackage

// ===== hw/rtl/tksi_front.sv =====
// ----------------------------------------------------------------------------
// tksi_front: input acceptance and classification.
// Classifies each transaction and holds it in a two-entry queue for the
// back end.
// ----------------------------------------------------------------------------
module tksi_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_req_type,
    input  logic                              s_qualified,
    input  logic signed [tksi_pkg::DATA_W-1:0] s_score,
    input  logic [tksi_pkg::DATA_W-1:0]        s_seq_index,
    input  logic signed [tksi_pkg::DATA_W-1:0] s_seed_payload,
    input  logic [tksi_pkg::RANK_W-1:0]        s_read_rank,
    output logic                              q_valid,
    output tksi_pkg::item_t                   q_item,
    input  logic                              q_pop
);

    tksi_pkg::item_t entry_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      cnt_reg, cnt_next;
    tksi_pkg::item_t new_item;
    logic            push;
    logic            pop;

    always_comb begin
        new_item.score     = s_score;
        new_item.seq_index = s_seq_index;
        new_item.seed      = s_seed_payload;
        new_item.read_rank = s_read_rank;
        if (s_req_type) begin
            new_item.cls = tksi_pkg::CLS_READ;
        end else if (s_qualified) begin
            new_item.cls = tksi_pkg::CLS_OFFER;
        end else begin
            new_item.cls = tksi_pkg::CLS_SKIP;
        end
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = entry_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// ===== hw/rtl/tksi_back.sv =====
// ----------------------------------------------------------------------------
// tksi_back: list sequencer and storage.
// Binary-searches the sorted list, shifts entries down one place at a time,
// places the new record, serves rank reads and registers the result.
// ----------------------------------------------------------------------------
module tksi_back #(
    parameter int unsigned CAPACITY = 512
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [tksi_pkg::LIMIT_W-1:0]       list_limit,
    input  logic                               q_valid,
    input  tksi_pkg::item_t                    q_item,
    output logic                               q_pop,
    output logic                               m_valid,
    input  logic                               m_ready,
    output tksi_pkg::result_t                  m_result
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned EW = ((CW > tksi_pkg::LIMIT_W) ? CW : tksi_pkg::LIMIT_W) + 1;
    localparam int unsigned RW = ((CW > tksi_pkg::RANK_W) ? CW : tksi_pkg::RANK_W) + 1;
    localparam int unsigned MW = 3 * tksi_pkg::DATA_W;
    localparam logic [EW-1:0] CAP_E = EW'(CAPACITY);

    logic [MW-1:0] mem [CAPACITY];
    logic [MW-1:0] rdata_reg;

    tksi_pkg::back_state_t state_reg, state_next;
    tksi_pkg::item_t       item_reg;
    tksi_pkg::result_t     res_reg;
    tksi_pkg::result_t     res_out;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         lo_reg;
    logic [CW-1:0]         hi_reg;
    logic [CW-1:0]         mid_reg;
    logic [CW-1:0]         idx_reg;
    logic                  grows_reg;
    logic                  m_valid_reg;
    tksi_pkg::result_t     m_result_reg;

    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [MW-1:0]         mem_wdata;

    logic [CW:0]           mid_sum;
    logic [CW-1:0]         mid;
    logic [EW-1:0]         eff_limit;
    logic [EW-1:0]         limit_e;
    logic                  has_room;
    logic                  will_insert;
    logic                  rank_in;
    logic [RW-1:0]         rank_e;
    logic signed [tksi_pkg::DATA_W-1:0] rd_score;
    logic [tksi_pkg::DATA_W-1:0]        rd_seq;
    logic                  beats;
    logic                  out_free;

    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = mid_sum[CW:1];
    assign limit_e   = EW'(list_limit);
    assign eff_limit = (limit_e > CAP_E) ? CAP_E : limit_e;
    assign has_room  = EW'(count_reg) < eff_limit;
    assign will_insert = has_room || (lo_reg < count_reg);
    assign rank_e    = RW'(item_reg.read_rank);
    assign rank_in   = rank_e < RW'(count_reg);
    assign rd_score  = rdata_reg[MW-1 -: tksi_pkg::DATA_W];
    assign rd_seq    = rdata_reg[2*tksi_pkg::DATA_W-1 -: tksi_pkg::DATA_W];
    // A kept entry is strictly better on a higher score, or on an equal score
    // with a lower sequence index.
    assign beats     = (rd_score > item_reg.score) ||
                       ((rd_score == item_reg.score) && (rd_seq < item_reg.seq_index));
    assign out_free  = !m_valid_reg || m_ready;

    // The result carries the count as it stands once the item is done.
    always_comb begin
        res_out             = res_reg;
        res_out.entry_count = tksi_pkg::COUNT_W'(count_reg);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tksi_pkg::BK_IDLE: begin
                if (q_valid) begin
                    case (q_item.cls)
                        tksi_pkg::CLS_OFFER: state_next = tksi_pkg::BK_SRCH;
                        tksi_pkg::CLS_READ:  state_next = tksi_pkg::BK_READ_RD;
                        default:             state_next = tksi_pkg::BK_RESULT;
                    endcase
                end
            end
            tksi_pkg::BK_SRCH: begin
                if (lo_reg < hi_reg) begin
                    state_next = tksi_pkg::BK_SRCH_CMP;
                end else if (will_insert) begin
                    state_next = tksi_pkg::BK_SHIFT;
                end else begin
                    state_next = tksi_pkg::BK_RESULT;
                end
            end
            tksi_pkg::BK_SRCH_CMP: state_next = tksi_pkg::BK_SRCH;
            tksi_pkg::BK_SHIFT: begin
                if (idx_reg > lo_reg) begin
                    state_next = tksi_pkg::BK_SHIFT_WR;
                end else begin
                    state_next = tksi_pkg::BK_PLACE;
                end
            end
            tksi_pkg::BK_SHIFT_WR: state_next = tksi_pkg::BK_SHIFT;
            tksi_pkg::BK_PLACE:    state_next = tksi_pkg::BK_RESULT;
            tksi_pkg::BK_READ_RD: begin
                state_next = rank_in ? tksi_pkg::BK_READ_WAIT : tksi_pkg::BK_RESULT;
            end
            tksi_pkg::BK_READ_WAIT: state_next = tksi_pkg::BK_RESULT;
            tksi_pkg::BK_RESULT: begin
                if (out_free) begin
                    state_next = tksi_pkg::BK_IDLE;
                end
            end
            default: state_next = tksi_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        q_pop     = 1'b0;
        mem_re    = 1'b0;
        mem_raddr = '0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = rdata_reg;
        case (state_reg)
            tksi_pkg::BK_IDLE: q_pop = q_valid;
            tksi_pkg::BK_SRCH: begin
                mem_re    = lo_reg < hi_reg;
                mem_raddr = mid[AW-1:0];
            end
            tksi_pkg::BK_SHIFT: begin
                mem_re    = idx_reg > lo_reg;
                mem_raddr = AW'(idx_reg - CW'(1));
            end
            tksi_pkg::BK_SHIFT_WR: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[AW-1:0];
            end
            tksi_pkg::BK_PLACE: begin
                mem_we    = 1'b1;
                mem_waddr = lo_reg[AW-1:0];
                mem_wdata = {item_reg.score, item_reg.seq_index, item_reg.seed};
            end
            tksi_pkg::BK_READ_RD: begin
                mem_re    = rank_in;
                mem_raddr = AW'(rank_e);
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tksi_pkg::BK_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == tksi_pkg::BK_PLACE && grows_reg) begin
                count_reg <= count_reg + CW'(1);
            end
            if (state_reg == tksi_pkg::BK_RESULT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            tksi_pkg::BK_IDLE: begin
                item_reg <= q_item;
                lo_reg   <= '0;
                hi_reg   <= count_reg;
                res_reg  <= '0;
            end
            tksi_pkg::BK_SRCH: begin
                mid_reg   <= mid;
                grows_reg <= has_room;
                idx_reg   <= has_room ? count_reg : count_reg - CW'(1);
            end
            tksi_pkg::BK_SRCH_CMP: begin
                if (beats) begin
                    lo_reg <= mid_reg + CW'(1);
                end else begin
                    hi_reg <= mid_reg;
                end
            end
            tksi_pkg::BK_SHIFT_WR: begin
                idx_reg <= idx_reg - CW'(1);
            end
            tksi_pkg::BK_PLACE: begin
                res_reg.inserted     <= 1'b1;
                res_reg.insert_rank  <= tksi_pkg::RANK_W'(lo_reg);
                res_reg.dropped_last <= !grows_reg;
            end
            tksi_pkg::BK_READ_WAIT: begin
                res_reg.entry_valid     <= 1'b1;
                res_reg.entry_score     <= rd_score;
                res_reg.entry_seq_index <= rd_seq;
                res_reg.entry_seed      <= rdata_reg[tksi_pkg::DATA_W-1:0];
            end
            tksi_pkg::BK_RESULT: begin
                if (out_free) begin
                    m_result_reg <= res_out;
                end
            end
            default: begin
                lo_reg <= lo_reg;
            end
        endcase
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

endmodule

// ===== hw/rtl/top_k_sorted_insert.sv =====
// ----------------------------------------------------------------------------
// top_k_sorted_insert: bounded top-K list kept in sorted order.
// An offer binary-searches the list in at most ceil(log2(count+1)) search steps;
// an inserted one then shifts n entries down one place at a time and places the
// new record, while one not inserted goes straight to its result.
// Throughput: one transaction at a time in the back end; one list memory access
// per search step and two (a read and a write) per shifted entry set it.
// Reset clears the queue and the entry count and loads the limit with 500; the
// list contents are not cleared, since only ranks below the count are ever read.
// ----------------------------------------------------------------------------
module top_k_sorted_insert #(
    parameter int unsigned CAPACITY = 512
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [tksi_pkg::LIMIT_W-1:0]       cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_req_type,
    input  logic                               s_qualified,
    input  logic signed [tksi_pkg::DATA_W-1:0] s_score,
    input  logic [tksi_pkg::DATA_W-1:0]        s_seq_index,
    input  logic signed [tksi_pkg::DATA_W-1:0] s_seed_payload,
    input  logic [tksi_pkg::RANK_W-1:0]        s_read_rank,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_inserted,
    output logic [tksi_pkg::RANK_W-1:0]        m_insert_rank,
    output logic                               m_dropped_last,
    output logic [tksi_pkg::COUNT_W-1:0]       m_entry_count,
    output logic                               m_entry_valid,
    output logic signed [tksi_pkg::DATA_W-1:0] m_entry_score,
    output logic [tksi_pkg::DATA_W-1:0]        m_entry_seq_index,
    output logic signed [tksi_pkg::DATA_W-1:0] m_entry_seed
);

    // The user is to write the limit register only while the block is idle; the block itself does not enforce this.
    logic [tksi_pkg::LIMIT_W-1:0] list_limit_reg;

    logic              q_valid;
    logic              q_pop;
    tksi_pkg::item_t   q_item;
    tksi_pkg::result_t result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            list_limit_reg <= tksi_pkg::LIMIT_RESET;
        end else if (cfg_wr_en) begin
            list_limit_reg <= cfg_wr_data;
        end
    end

    // The front end classifies each transaction and queues it, so input acceptance
    // continues, until the two-entry queue fills, while the back end is busy with a long shift.
    tksi_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_qualified    (s_qualified),
        .s_score        (s_score),
        .s_seq_index    (s_seq_index),
        .s_seed_payload (s_seed_payload),
        .s_read_rank    (s_read_rank),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop)
    );

    // The back end owns the list memory and the output register.
    tksi_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .list_limit (list_limit_reg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_result   (result)
    );

    assign m_inserted        = result.inserted;
    assign m_insert_rank     = result.insert_rank;
    assign m_dropped_last    = result.dropped_last;
    assign m_entry_count     = result.entry_count;
    assign m_entry_valid     = result.entry_valid;
    assign m_entry_score     = result.entry_score;
    assign m_entry_seq_index = result.entry_seq_index;
    assign m_entry_seed      = result.entry_seed;

endmodule

// ===== verif/top_k_sorted_insert_tb.sv =====
// ----------------------------------------------------------------------------
// top_k_sorted_insert_tb: self-checking bench for the top-K sorted list.
// Drives offers and reads through the valid/ready input channel, predicts each
// result with a behavioral copy of the ranked list, and compares every field
// of every result transaction. Runs through several list limits, idle and
// stall patterns, and a long receiver hold-off that fills the block up.
// ----------------------------------------------------------------------------
module top_k_sorted_insert_tb;

    localparam int unsigned CAP       = 512;
    localparam int unsigned WDOG_MAX  = 20000;
    localparam int unsigned HOLD_LEN  = 3000;
    localparam logic        REQ_OFFER = 1'b0;
    localparam logic        REQ_READ  = 1'b1;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [tksi_pkg::LIMIT_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_req_type = 1'b0;
    logic s_qualified = 1'b0;
    logic signed [tksi_pkg::DATA_W-1:0] s_score = '0;
    logic [tksi_pkg::DATA_W-1:0] s_seq_index = '0;
    logic signed [tksi_pkg::DATA_W-1:0] s_seed_payload = '0;
    logic [tksi_pkg::RANK_W-1:0] s_read_rank = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_inserted;
    logic [tksi_pkg::RANK_W-1:0] m_insert_rank;
    logic m_dropped_last;
    logic [tksi_pkg::COUNT_W-1:0] m_entry_count;
    logic m_entry_valid;
    logic signed [tksi_pkg::DATA_W-1:0] m_entry_score;
    logic [tksi_pkg::DATA_W-1:0] m_entry_seq_index;
    logic signed [tksi_pkg::DATA_W-1:0] m_entry_seed;

    top_k_sorted_insert #(.CAPACITY(CAP)) dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // The bench's own copy of the ranked list and its limit.
    logic signed [tksi_pkg::DATA_W-1:0] list_score [CAP];
    logic [tksi_pkg::DATA_W-1:0]        list_seq   [CAP];
    logic signed [tksi_pkg::DATA_W-1:0] list_seed  [CAP];
    int unsigned                        list_fill;
    int unsigned                        list_limit;

    tksi_pkg::result_t pending_results[$];
    int unsigned error_count = 0;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_cycles;
    int unsigned quiet_cycles;
    logic        hold_request;
    logic        hold_seen = 1'b0;

    // Seq indices handed out in random offers; small range makes ties common.
    logic [tksi_pkg::DATA_W-1:0] next_seq;

    // Predicts the result of one item and updates the list copy.
    function automatic tksi_pkg::result_t predict_list_item(logic req, logic qual,
            logic signed [tksi_pkg::DATA_W-1:0] sc, logic [tksi_pkg::DATA_W-1:0] sq,
            logic signed [tksi_pkg::DATA_W-1:0] sd, logic [tksi_pkg::RANK_W-1:0] rk);
        tksi_pkg::result_t r;
        int unsigned eff;
        int unsigned pos;
        int unsigned last;
        bit grows;
        r = '0;
        if (req == REQ_OFFER) begin
            if (qual) begin
                eff = (list_limit > CAP) ? CAP : list_limit;
                pos = 0;
                // Walk past every entry that is strictly better.
                while (pos < list_fill && (list_score[pos] > sc ||
                       (list_score[pos] == sc && list_seq[pos] < sq)))
                    pos++;
                if (list_fill < eff || pos < list_fill) begin
                    grows = (list_fill < eff);
                    last = grows ? list_fill : list_fill - 1;
                    for (int i = last; i > pos; i--) begin
                        list_score[i] = list_score[i-1];
                        list_seq[i]   = list_seq[i-1];
                        list_seed[i]  = list_seed[i-1];
                    end
                    list_score[pos] = sc;
                    list_seq[pos]   = sq;
                    list_seed[pos]  = sd;
                    if (grows)
                        list_fill++;
                    r.inserted     = 1'b1;
                    r.insert_rank  = pos[tksi_pkg::RANK_W-1:0];
                    r.dropped_last = !grows;
                end
            end
        end else if (rk < list_fill) begin
            r.entry_valid     = 1'b1;
            r.entry_score     = list_score[rk];
            r.entry_seq_index = list_seq[rk];
            r.entry_seed      = list_seed[rk];
        end
        r.entry_count = list_fill[tksi_pkg::COUNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [tksi_pkg::DATA_W-1:0] got,
            logic [tksi_pkg::DATA_W-1:0] want);
        error_count++;
        $display("ERROR %s: got %h expected %h", what, got, want);
    endtask

    // Sends one transaction; the expectation is queued at acceptance. Valid
    // is dropped only when the sender idles or the stream pauses.
    task automatic send_list_item(logic req, logic qual,
            logic signed [tksi_pkg::DATA_W-1:0] sc, logic [tksi_pkg::DATA_W-1:0] sq,
            logic signed [tksi_pkg::DATA_W-1:0] sd, logic [tksi_pkg::RANK_W-1:0] rk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_req_type     <= req;
        s_qualified    <= qual;
        s_score        <= sc;
        s_seq_index    <= sq;
        s_seed_payload <= sd;
        s_read_rank    <= rk;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pending_results.insert(pending_results.size(),
                               predict_list_item(req, qual, sc, sq, sd, rk));
    endtask

    // Receiver: random stalls, plus a long hold-off counted here once requested.
    always @(posedge aclk) begin
        hold_seen <= hold_request;
        if (hold_request && !hold_seen) begin
            hold_cycles <= HOLD_LEN;
            m_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result checker.
    always @(posedge aclk) begin
        tksi_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", '0, '0);
            end else begin
                want = pending_results.pop_front();
                if (m_inserted !== want.inserted)
                    report_mismatch("inserted", 64'(m_inserted), 64'(want.inserted));
                if (m_insert_rank !== want.insert_rank)
                    report_mismatch("insert_rank", 64'(m_insert_rank),
                                    64'(want.insert_rank));
                if (m_dropped_last !== want.dropped_last)
                    report_mismatch("dropped_last", 64'(m_dropped_last),
                                    64'(want.dropped_last));
                if (m_entry_count !== want.entry_count)
                    report_mismatch("entry_count", 64'(m_entry_count),
                                    64'(want.entry_count));
                if (m_entry_valid !== want.entry_valid)
                    report_mismatch("entry_valid", 64'(m_entry_valid),
                                    64'(want.entry_valid));
                if (m_entry_score !== want.entry_score)
                    report_mismatch("entry_score", m_entry_score, want.entry_score);
                if (m_entry_seq_index !== want.entry_seq_index)
                    report_mismatch("entry_seq_index", m_entry_seq_index,
                                    want.entry_seq_index);
                if (m_entry_seed !== want.entry_seed)
                    report_mismatch("entry_seed", m_entry_seed, want.entry_seed);
            end
        end
    end

    // Watchdog: a long stretch with no transaction on either channel is a hang.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn ||
            hold_cycles > 0)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("top_k_sorted_insert: mismatch");
            $finish;
        end
    end

    // Waits until every expected result has come, then lets the block settle.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // The limit is only changed while the block is idle.
    task automatic write_list_limit(int unsigned value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[tksi_pkg::LIMIT_W-1:0];
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        list_limit = value;
    endtask

    function automatic logic [tksi_pkg::DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Scores are drawn from a narrow band most of the time so ties happen.
    function automatic logic signed [tksi_pkg::DATA_W-1:0] rand_score();
        case ($urandom_range(3))
            0: return rand64();
            default: return $signed(64'($urandom_range(40))) - 64'sd20;
        endcase
    endfunction

    task automatic send_random_offer();
        logic [tksi_pkg::DATA_W-1:0] sq;
        if ($urandom_range(7) == 0)
            sq = rand64();
        else
            sq = next_seq + 64'($urandom_range(3));
        next_seq = next_seq + 64'd1;
        send_list_item(REQ_OFFER, $urandom_range(9) != 0, rand_score(), sq,
                       rand64(), 9'($urandom_range(511)));
    endtask

    task automatic send_random_read();
        int unsigned rk;
        if (list_fill > 0 && $urandom_range(5) != 0)
            rk = $urandom_range(list_fill - 1);
        else
            rk = $urandom_range(511);
        send_list_item(REQ_READ, 1'($urandom_range(1)), rand64(), rand64(),
                       rand64(), rk[tksi_pkg::RANK_W-1:0]);
    endtask

    task automatic send_random_items(int unsigned count);
        repeat (count) begin
            if ($urandom_range(3) == 0)
                send_random_read();
            else
                send_random_offer();
        end
    endtask

    // Field extremes, ties, unqualified offers, out-of-range reads.
    task automatic test_directed();
        send_list_item(REQ_READ, 1'b0, '0, '0, '0, 9'd0);
        send_list_item(REQ_OFFER, 1'b1, 64'sh7fff_ffff_ffff_ffff, '0, '1, 9'd511);
        send_list_item(REQ_OFFER, 1'b1, 64'sh8000_0000_0000_0000, '1,
                       64'sh8000_0000_0000_0000, '0);
        send_list_item(REQ_OFFER, 1'b0, 64'sh7fff_ffff_ffff_ffff, '0, '0, '0);
        send_list_item(REQ_OFFER, 1'b1, 64'sd5, 64'd10, 64'sd1, '0);
        send_list_item(REQ_OFFER, 1'b1, 64'sd5, 64'd9, 64'sd2, '0);
        send_list_item(REQ_OFFER, 1'b1, 64'sd5, 64'd10, 64'sd3, '0);
        send_list_item(REQ_OFFER, 1'b1, -64'sd1, 64'd0, 64'sd4, '0);
        for (int i = 0; i < 8; i++)
            send_list_item(REQ_READ, 1'b1, '1, '1, '1, i[tksi_pkg::RANK_W-1:0]);
        send_list_item(REQ_READ, 1'b0, '0, '0, '0, 9'd511);
        send_list_item(REQ_READ, 1'b0, '0, '0, '0, 9'd256);
    endtask

    // Small limits exercise the full-list drop path, including a zero limit.
    task automatic test_limits();
        write_list_limit(3);
        send_random_items(60);
        write_list_limit(0);
        send_random_items(40);
        write_list_limit(1);
        send_random_items(40);
        write_list_limit(1023);
        send_random_items(40);
        write_list_limit(512);
    endtask

    task automatic test_idle_patterns();
        send_idle_pct = 36;
        recv_stall_pct = 45;
        send_random_items(250);
        send_idle_pct = 45;
        recv_stall_pct = 36;
        send_random_items(250);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_random_items(250);
    endtask

    // The receiver holds off while transactions keep coming, so input stalls.
    task automatic test_backpressure();
        write_list_limit(20);
        hold_request = 1'b1;
        send_random_items(80);
        write_list_limit(500);
        send_random_items(80);
    endtask

    initial begin
        list_fill = 0;
        list_limit = int'(tksi_pkg::LIMIT_RESET);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 1'b0;
        next_seq = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_limits();
        test_idle_patterns();
        test_backpressure();
        drain_results();
        if (error_count == 0)
            $display("top_k_sorted_insert: match");
        else
            $display("top_k_sorted_insert: mismatch");
        $finish;
    end

endmodule
